/* rtl/opbd_pkg.sv */
package opbd_pkg;

	localparam int SampleW  = 16;
	localparam int AccW     = 31;
	localparam int QShift   = 15;
	localparam int DcShift  = 4;
	localparam int TapDepth = 32;
	localparam int AddrW    = $clog2(TapDepth);
	localparam int NumTaps  = 23;
	localparam int NumPairs = (NumTaps + 1) / 2;
	localparam int PairW    = $clog2(NumPairs);
	localparam int CoefW    = 13;
	localparam int ProdW    = SampleW + CoefW + 1;
	localparam int SumW     = 32;
	localparam int CfgIndexW = 8;

	localparam logic [CfgIndexW-1:0] RegLowLimit  = CfgIndexW'(0);
	localparam logic [CfgIndexW-1:0] RegHighLimit = CfgIndexW'(1);

	localparam logic [SampleW-1:0] LowLimitReset  = SampleW'(20);
	localparam logic [SampleW-1:0] HighLimitReset = SampleW'(1000);

	typedef struct packed {
		logic               start;
		logic [SampleW-1:0] entry;
	} fir_ctrl_t;

	typedef struct packed {
		logic               done;
		logic [SampleW-1:0] ac;
	} fir_stat_t;

	function automatic logic [CoefW-1:0] coef(input logic [PairW-1:0] k);
		logic [CoefW-1:0] c;
		case (k)
			PairW'(0):  c = CoefW'(172);
			PairW'(1):  c = CoefW'(321);
			PairW'(2):  c = CoefW'(579);
			PairW'(3):  c = CoefW'(927);
			PairW'(4):  c = CoefW'(1360);
			PairW'(5):  c = CoefW'(1858);
			PairW'(6):  c = CoefW'(2390);
			PairW'(7):  c = CoefW'(2916);
			PairW'(8):  c = CoefW'(3391);
			PairW'(9):  c = CoefW'(3768);
			PairW'(10): c = CoefW'(4012);
			PairW'(11): c = CoefW'(4096);
			default:    c = '0;
		endcase
		return c;
	endfunction

endpackage

/* rtl/opbd_if.sv */
interface opbd_sample_if;
	logic                        valid;
	logic                        ready;
	logic [opbd_pkg::SampleW-1:0] sample;
	modport source (output valid, sample, input ready);
	modport sink (input valid, sample, output ready);
endinterface

interface opbd_result_if;
	logic                               valid;
	logic                               ready;
	logic                               beat_detected;
	logic signed [opbd_pkg::SampleW-1:0] ac_value;
	logic [opbd_pkg::SampleW-1:0]        dc_estimate;
	modport source (output valid, beat_detected, ac_value, dc_estimate, input ready);
	modport sink (input valid, beat_detected, ac_value, dc_estimate, output ready);
endinterface

interface opbd_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [opbd_pkg::CfgIndexW-1:0] index;
	logic [opbd_pkg::SampleW-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/opbd_ram.sv */
module opbd_ram #(
	parameter int Width = 16,
	parameter int Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr_a,
	input  logic [$clog2(Depth)-1:0] raddr_b,
	output logic [Width-1:0]         rdata_a,
	output logic [Width-1:0]         rdata_b
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

/* rtl/opbd_dc.sv */
module opbd_dc (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [opbd_pkg::SampleW-1:0] sample,
	output logic [opbd_pkg::SampleW-1:0] dc,
	output logic [opbd_pkg::SampleW-1:0] entry
);

	logic [opbd_pkg::AccW-1:0] acc_q;
	logic signed [opbd_pkg::AccW:0] diff;
	logic signed [opbd_pkg::AccW:0] delta;

	// The arithmetic shift rounds the step towards minus infinity.
	assign diff  = $signed({1'b0, sample, opbd_pkg::QShift'(0)}) - $signed({1'b0, acc_q});
	assign delta = diff >>> opbd_pkg::DcShift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (step) begin
			acc_q <= acc_q + delta[opbd_pkg::AccW-1:0];
		end
	end

	assign dc    = acc_q[opbd_pkg::AccW-1:opbd_pkg::QShift];
	assign entry = sample - dc;

endmodule

/* rtl/opbd_fir.sv */
module opbd_fir (
	input  logic                clk,
	input  logic                arst_n,
	input  opbd_pkg::fir_ctrl_t ctrl,
	output opbd_pkg::fir_stat_t stat
);

	localparam logic [1:0] F_IDLE  = 2'd0;
	localparam logic [1:0] F_ISSUE = 2'd1;
	localparam logic [1:0] F_DRAIN = 2'd2;
	localparam logic [opbd_pkg::PairW-1:0] LastPair = opbd_pkg::PairW'(opbd_pkg::NumPairs - 1);

	logic [1:0]                        state_q;
	logic [opbd_pkg::AddrW-1:0]        wp_q;
	logic [opbd_pkg::TapDepth-1:0]     valid_q;
	logic [opbd_pkg::PairW-1:0]        k_q;
	logic [opbd_pkg::AddrW-1:0]        addr_a;
	logic [opbd_pkg::AddrW-1:0]        addr_b;
	logic [opbd_pkg::SampleW-1:0]      rdata_a;
	logic [opbd_pkg::SampleW-1:0]      rdata_b;
	logic                              v_s1;
	logic                              va_s1;
	logic                              vb_s1;
	logic [opbd_pkg::PairW-1:0]        k_s1;
	logic                              v_s2;
	logic signed [opbd_pkg::ProdW-1:0] prod_s2;
	logic signed [opbd_pkg::SumW-1:0]  sum_q;
	logic [opbd_pkg::SampleW-1:0]      tap_a;
	logic [opbd_pkg::SampleW-1:0]      tap_b;
	logic signed [opbd_pkg::SampleW-1:0] pair;
	logic                              issue;

	// Pair k takes the taps k and (NumTaps-1-k) behind the newest entry.
	assign addr_a = wp_q - opbd_pkg::AddrW'(k_q);
	assign addr_b = wp_q + opbd_pkg::AddrW'(k_q) - opbd_pkg::AddrW'(opbd_pkg::NumTaps - 1);
	assign issue  = (state_q == F_ISSUE);

	opbd_ram #(
		.Width (opbd_pkg::SampleW),
		.Depth (opbd_pkg::TapDepth)
	) u_ram (
		.clk     (clk),
		.we      (ctrl.start),
		.waddr   (wp_q),
		.wdata   (ctrl.entry),
		.raddr_a (addr_a),
		.raddr_b (addr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// Entries never written since reset read as zero.
	assign tap_a = va_s1 ? rdata_a : '0;
	assign tap_b = vb_s1 ? rdata_b : '0;
	assign pair  = (k_s1 == LastPair) ? $signed(tap_a) : $signed(tap_a + tap_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			wp_q    <= '0;
			valid_q <= '0;
			k_q     <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			case (state_q)
				F_IDLE: begin
					if (ctrl.start) begin
						valid_q[wp_q] <= 1'b1;
						k_q           <= '0;
						state_q       <= F_ISSUE;
					end
				end
				F_ISSUE: begin
					k_q <= k_q + opbd_pkg::PairW'(1);
					if (k_q == LastPair) begin
						state_q <= F_DRAIN;
					end
				end
				F_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						wp_q    <= wp_q + opbd_pkg::AddrW'(1);
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		va_s1   <= valid_q[addr_a];
		vb_s1   <= valid_q[addr_b];
		k_s1    <= k_q;
		prod_s2 <= pair * $signed({1'b0, opbd_pkg::coef(k_s1)});
		if (ctrl.start) begin
			sum_q <= '0;
		end else if (v_s2) begin
			sum_q <= sum_q + opbd_pkg::SumW'(prod_s2);
		end
	end

	assign stat.done = (state_q == F_DRAIN) && !v_s1 && !v_s2;
	assign stat.ac   = sum_q[opbd_pkg::QShift+opbd_pkg::SampleW-1:opbd_pkg::QShift];

endmodule

/* rtl/opbd_beat.sv */
module opbd_beat (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  logic [opbd_pkg::SampleW-1:0] cur,
	input  logic [opbd_pkg::SampleW-1:0] low_limit,
	input  logic [opbd_pkg::SampleW-1:0] high_limit,
	output logic                         beat
);

	logic signed [opbd_pkg::SampleW-1:0] prev_q, max_q, min_q;
	logic signed [opbd_pkg::SampleW-1:0] max_d, min_d, cur_s;
	logic                                pos_q, neg_q, pos_d, neg_d;
	logic                                rise, fall;
	logic signed [opbd_pkg::SampleW:0]   amp;

	assign cur_s = $signed(cur);
	assign rise  = (prev_q < 0) && (cur_s >= 0);
	assign fall  = (prev_q > 0) && (cur_s <= 0);
	assign amp   = $signed({max_q[opbd_pkg::SampleW-1], max_q})
	             - $signed({min_q[opbd_pkg::SampleW-1], min_q});
	assign beat  = rise && (amp > $signed({1'b0, low_limit}))
	                    && (amp < $signed({1'b0, high_limit}));

	always_comb begin
		pos_d = pos_q;
		neg_d = neg_q;
		max_d = max_q;
		min_d = min_q;
		if (rise) begin
			pos_d = 1'b1;
			neg_d = 1'b0;
			max_d = '0;
		end
		if (fall) begin
			pos_d = 1'b0;
			neg_d = 1'b1;
			min_d = '0;
		end
		if (pos_d && (cur_s > prev_q)) begin
			max_d = cur_s;
		end
		if (neg_d && (cur_s < prev_q)) begin
			min_d = cur_s;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			max_q  <= '0;
			min_q  <= '0;
			pos_q  <= 1'b0;
			neg_q  <= 1'b0;
		end else if (fire) begin
			prev_q <= cur_s;
			max_q  <= max_d;
			min_q  <= min_d;
			pos_q  <= pos_d;
			neg_q  <= neg_d;
		end
	end

endmodule

/* rtl/optical_pulse_beat_detector.sv */
// Channel   Dir  Payload                                   Handshake
// samples   in   sample[15:0]                              valid / ready
// results   out  beat_detected, ac_value[15:0], dc_estimate valid / ready
// cfg       in   index[7:0], data[15:0]                    valid / ready
//
// A sample passes in order through the DC update and delay-line write, the twelve folded
// tap pairs through the single multiplier, the drain of its pipeline and the hand-over of
// the result.
// Reset clears the DC level, the write pointer, the delay-line valid bits and the half-cycle
// tracking, and sets the limits back to 20 and 1000.
// A new sample is taken while the previous result waits; a stalled result holds the next one.
module optical_pulse_beat_detector (
	input  logic                 clk,
	input  logic                 arst_n,
	opbd_sample_if.sink          samples,
	opbd_result_if.source        results,
	opbd_cfg_if.sink             cfg
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DC   = 3'd1;
	localparam logic [2:0] S_WR   = 3'd2;
	localparam logic [2:0] S_FIR  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]                   state_q;
	logic [opbd_pkg::SampleW-1:0] x_q;
	logic [opbd_pkg::SampleW-1:0] ac_q;
	logic [opbd_pkg::SampleW-1:0] low_q, high_q;
	logic [opbd_pkg::SampleW-1:0] dc, entry;
	logic                         out_valid_q;
	logic                         out_free;
	logic                         load;
	logic                         beat;
	opbd_pkg::fir_ctrl_t          fir_ctrl;
	opbd_pkg::fir_stat_t          fir_stat;

	assign samples.ready = (state_q == S_IDLE);
	assign cfg.ready     = 1'b1;
	assign out_free      = !out_valid_q || results.ready;
	assign load          = (state_q == S_OUT) && out_free;

	opbd_dc u_dc (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (state_q == S_DC),
		.sample (x_q),
		.dc     (dc),
		.entry  (entry)
	);

	assign fir_ctrl.start = (state_q == S_WR);
	assign fir_ctrl.entry = entry;

	opbd_fir u_fir (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (fir_ctrl),
		.stat   (fir_stat)
	);

	opbd_beat u_beat (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (load),
		.cur        (ac_q),
		.low_limit  (low_q),
		.high_limit (high_q),
		.beat       (beat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			low_q       <= opbd_pkg::LowLimitReset;
			high_q      <= opbd_pkg::HighLimitReset;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					opbd_pkg::RegLowLimit:  low_q  <= cfg.data;
					opbd_pkg::RegHighLimit: high_q <= cfg.data;
					default: ;
				endcase
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (samples.valid) begin
						state_q <= S_DC;
					end
				end
				S_DC: state_q <= S_WR;
				S_WR: state_q <= S_FIR;
				S_FIR: begin
					if (fir_stat.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			x_q <= samples.sample;
		end
		if (fir_stat.done) begin
			ac_q <= fir_stat.ac;
		end
		if (load) begin
			results.beat_detected <= beat;
			results.ac_value      <= $signed(ac_q);
			results.dc_estimate   <= dc;
		end
	end

	assign results.valid = out_valid_q;

endmodule
